// ----- hdl/mmf_pkg.sv -----
// Shared types, constants and the nine-input median network of the 3x3 mean/median filter.
// Used by mmf_kernel and mean_median_filter_3x3; depends on nothing else.

package mmf_pkg;

   localparam int PIX_W = 8;
   typedef logic [PIX_W-1:0] pix_type;

   // The nine neighbours of one window, in no particular order.
   localparam int WIN_N = 9;
   typedef pix_type [WIN_N-1:0] window_type;

   // One line-store entry holds the same column of the two previous rows.
   typedef struct packed {
      pix_type upper;   // row r-2
      pix_type lower;   // row r-1
   } line_pair_type;

   // Register file.
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int IMG_WIDTH_W  = 11;
   localparam int IMG_HEIGHT_W = 12;

   localparam logic [CSR_ADDR_W-1:0] ADDR_IMAGE_WIDTH  = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_IMAGE_HEIGHT = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_FILTER_MODE  = 4'h8;

   localparam logic [IMG_WIDTH_W-1:0]  RESET_IMAGE_WIDTH  = 11'd640;
   localparam logic [IMG_HEIGHT_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

   localparam logic MODE_MEAN   = 1'b0;
   localparam logic MODE_MEDIAN = 1'b1;

   // Smallest frame dimension that still has an interior pixel.
   localparam int MIN_DIM = 3;
   localparam int MAX_LINE_WIDTH_DEF = 1024;

   // Division of the window sum by nine: floor(sum * 7282 / 2^16) is exact for
   // every sum of nine bytes.
   localparam int SUM_W      = 12;
   localparam int RECIP_W    = 13;
   localparam int MEAN_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

   // Nineteen compare-exchange steps of the classic median-of-nine network.
   // After them the median sits in element four.
   localparam int NET_N = 19;
   localparam int unsigned NET_LO [NET_N] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0,
                                              5, 4, 3, 1, 2, 4, 4, 6, 4};
   localparam int unsigned NET_HI [NET_N] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3,
                                              8, 7, 6, 4, 5, 7, 2, 4, 2};

   function automatic pix_type median9(input window_type win);
      window_type v;
      pix_type    a;
      pix_type    b;
      v = win;
      for (int i = 0; i < NET_N; i++) begin
         a = v[NET_LO[i]];
         b = v[NET_HI[i]];
         if (a > b) begin
            v[NET_LO[i]] = b;
            v[NET_HI[i]] = a;
         end
      end
      return v[4];
   endfunction

endpackage

// ----- hdl/mmf_kernel.sv -----
// Window arithmetic of the 3x3 filter: truncated mean or median of nine pixels.
// Purely combinational; depends on mmf_pkg.

module mmf_kernel (
   input  mmf_pkg::window_type win,
   input  logic                mode,
   output mmf_pkg::pix_type    result
);
   import mmf_pkg::*;

   logic [SUM_W-1:0]           sum;
   logic [SUM_W+RECIP_W-1:0]   product;
   pix_type                    mean;
   pix_type                    median;

   always_comb begin
      sum = '0;
      for (int i = 0; i < WIN_N; i++) begin
         sum = sum + SUM_W'(win[i]);
      end
   end

   // Division by nine through the scaled reciprocal.
   assign product = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_NINE);
   assign mean    = PIX_W'(product >> MEAN_SHIFT);
   assign median  = median9(win);

   assign result = (mode == MODE_MEDIAN) ? median : mean;

endmodule

// ----- hdl/mean_median_filter_3x3.sv -----
// Top level of the 3x3 mean/median filter: register port, line store, window and output stage.
// Depends on mmf_pkg and mmf_kernel.

// The filter takes one 8-bit grey pixel per transfer in raster order and gives one result
// transfer for every interior pixel of the frame, in raster order, carrying the truncated
// mean or the median of its 3x3 neighbourhood; the result for the last interior pixel is
// marked with last_in_frame. It sustains one pixel per clock cycle while the output is not
// stalled: a pixel is registered together with the line-store read of its column, and when
// it moves on from there the window arithmetic is done and the result is registered. Border
// pixels produce no result transfer. The line store is a single memory with one read and one
// write port that holds the two previous rows side by side; it needs no clearing after reset,
// since the first two rows of every frame, which read it before it is written, produce no
// results. Frame size and mode must be written through the register port while no pixel is
// in flight; the block does not enforce this. A write to width or height starts a new frame.
// A width outside 3 to MAX_LINE_WIDTH is saturated into that range, and a height below 3 is
// taken as 3.

module mean_median_filter_3x3 #(
   parameter int MAX_LINE_WIDTH = mmf_pkg::MAX_LINE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mmf_pkg::pix_type                req_pixel_in,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mmf_pkg::pix_type                rsp_filtered_pixel,
   output logic                            rsp_last_in_frame,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mmf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [mmf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mmf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import mmf_pkg::*;

   localparam int COL_W = $clog2(MAX_LINE_WIDTH);
   localparam int EFF_W = $clog2(MAX_LINE_WIDTH + 1);

   // Stage one holds the accepted pixel while the line store is being read.
   typedef struct packed {
      pix_type          pixel;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             last;
   } stage_type;

   // ---------------------------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------------------------
   logic [IMG_WIDTH_W-1:0]  image_width_ff,  image_width_in;
   logic [IMG_HEIGHT_W-1:0] image_height_ff, image_height_in;
   logic                    filter_mode_ff,  filter_mode_in;
   logic                    csr_write;
   logic                    size_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      filter_mode_in  = filter_mode_ff;
      size_write      = 1'b0;
      if (csr_write) begin
         unique case (csr_paddr)
            ADDR_IMAGE_WIDTH: begin
               image_width_in = csr_pwdata[IMG_WIDTH_W-1:0];
               size_write     = 1'b1;
            end
            ADDR_IMAGE_HEIGHT: begin
               image_height_in = csr_pwdata[IMG_HEIGHT_W-1:0];
               size_write      = 1'b1;
            end
            ADDR_FILTER_MODE: begin
               filter_mode_in = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(image_width_ff);
         ADDR_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(image_height_ff);
         ADDR_FILTER_MODE:  csr_prdata = CSR_DATA_W'(filter_mode_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RESET_IMAGE_WIDTH;
         image_height_ff <= RESET_IMAGE_HEIGHT;
         filter_mode_ff  <= MODE_MEDIAN;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         filter_mode_ff  <= filter_mode_in;
      end
   end

   // Effective frame size: the width is saturated into the range the line store can hold,
   // the height is raised to the smallest usable value.
   logic [EFF_W-1:0]        eff_width;
   logic [IMG_HEIGHT_W-1:0] eff_height;

   always_comb begin
      if (32'(image_width_ff) < 32'(MIN_DIM)) begin
         eff_width = EFF_W'(MIN_DIM);
      end else if (32'(image_width_ff) > 32'(MAX_LINE_WIDTH)) begin
         eff_width = EFF_W'(MAX_LINE_WIDTH);
      end else begin
         eff_width = EFF_W'(image_width_ff);
      end
      if (32'(image_height_ff) < 32'(MIN_DIM)) begin
         eff_height = IMG_HEIGHT_W'(MIN_DIM);
      end else begin
         eff_height = image_height_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Handshake and flow control
   // ---------------------------------------------------------------------------------------
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff,       s1_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      advance;

   // The item in stage one moves on unless it carries a result and the output register
   // is still holding one that has not been taken. Items without a result never wait.
   assign advance   = s1_valid_ff &&
                      (!s1_ff.emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------------------------
   // Position counters
   // ---------------------------------------------------------------------------------------
   logic [COL_W-1:0]        col_ff, col_in;
   logic [IMG_HEIGHT_W-1:0] row_ff, row_in;
   logic [COL_W-1:0]        col_cur;
   logic [IMG_HEIGHT_W-1:0] row_cur;
   logic                    cur_last;
   logic                    cur_emit;

   always_comb begin
      // Counters can only lie beyond the frame after a change of size; start over then.
      col_cur = (32'(col_ff) >= 32'(eff_width))  ? '0 : col_ff;
      row_cur = (32'(row_ff) >= 32'(eff_height)) ? '0 : row_ff;

      cur_last = (32'(row_cur) == 32'(eff_height) - 32'd1) &&
                 (32'(col_cur) == 32'(eff_width) - 32'd1);
      cur_emit = (32'(row_cur) >= 32'd2) && (32'(col_cur) >= 32'd2);

      col_in = col_ff;
      row_in = row_ff;
      if (size_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (32'(col_cur) + 32'd1 >= 32'(eff_width)) begin
            col_in = '0;
            row_in = (32'(row_cur) + 32'd1 >= 32'(eff_height)) ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage one: accepted pixel and line-store read
   // ---------------------------------------------------------------------------------------
   always_comb begin
      s1_in.pixel = req_pixel_in;
      s1_in.col   = col_cur;
      s1_in.emit  = cur_emit;
      s1_in.last  = cur_last;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // The line store is read at the column of the accepted pixel and written when the item
   // leaves stage one: the lower row moves up and the new pixel takes its place.
   // Reads and writes always fall on different columns, since a row has at least three.
   line_pair_type line_mem [MAX_LINE_WIDTH];
   line_pair_type line_rd_ff;
   line_pair_type line_wr;

   assign line_wr.upper = line_rd_ff.lower;
   assign line_wr.lower = s1_ff.pixel;

   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_cur];
      end
      if (advance) begin
         line_mem[s1_ff.col] <= line_wr;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Window of the two previous columns
   // ---------------------------------------------------------------------------------------
   // Index 0..2 hold column c-2 (top, middle, bottom), 3..5 column c-1.
   pix_type [5:0] win_cols_ff, win_cols_in;
   window_type    window;

   always_comb begin
      win_cols_in = win_cols_ff;
      if (advance) begin
         win_cols_in[0] = win_cols_ff[3];
         win_cols_in[1] = win_cols_ff[4];
         win_cols_in[2] = win_cols_ff[5];
         win_cols_in[3] = line_rd_ff.upper;
         win_cols_in[4] = line_rd_ff.lower;
         win_cols_in[5] = s1_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cols_ff <= '0;
      end else begin
         win_cols_ff <= win_cols_in;
      end
   end

   assign window = {win_cols_ff[0], win_cols_ff[3], line_rd_ff.upper,
                    win_cols_ff[1], win_cols_ff[4], line_rd_ff.lower,
                    win_cols_ff[2], win_cols_ff[5], s1_ff.pixel};

   // ---------------------------------------------------------------------------------------
   // Arithmetic and output register
   // ---------------------------------------------------------------------------------------
   pix_type result;
   pix_type rsp_pixel_ff;
   logic    rsp_last_ff;
   logic    load_rsp;

   mmf_kernel u_kernel (
      .win    (window),
      .mode   (filter_mode_ff),
      .result (result)
   );

   assign load_rsp = advance && s1_ff.emit;

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_pixel_ff <= result;
         rsp_last_ff  <= s1_ff.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_pixel = rsp_pixel_ff;
   assign rsp_last_in_frame  = rsp_last_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   // The column counter never leaves the effective row once out of reset.
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(eff_width))
      else $error("column counter beyond effective width");

   // The row counter never leaves the effective frame.
   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < 32'(eff_height))
      else $error("row counter beyond effective height");

   // A new pixel only enters stage one when it is empty or the item there moves on in the same cycle.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_valid_ff || advance))
      else $error("stage one overwritten");

   // A result in stage one must wait while the output register is full and stalled.
   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.emit && rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("result dropped behind a stalled output");

   // A held result is still there, unchanged, in the next cycle.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_pixel_ff)))
      else $error("stalled result changed");

endmodule
